### src/mbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbt_pkg;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned TOTAL_W = 7;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_COUNT  = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAST,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

### src/mbt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mbt_req_if import mbt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   opcode_type           opcode;
   logic [KEY_W-1:0]     key;

   modport source (output valid, output opcode, output key, input ready);
   modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface mbt_rsp_if import mbt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 done_ok;
   logic                 rejected_full;
   logic [TOTAL_W-1:0]   match_count;
   logic                 is_present;
   logic [TOTAL_W-1:0]   entry_total;
   logic                 is_empty;

   modport source (output valid, output done_ok, output rejected_full, output match_count,
                   output is_present, output entry_total, output is_empty, input ready);
   modport sink   (input valid, input done_ok, input rejected_full, input match_count,
                   input is_present, input entry_total, input is_empty, output ready);
endinterface

`default_nettype wire

### src/mbt_store.sv
`timescale 1ns / 1ps
`default_nettype none

module mbt_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/multiset_bag_table.sv
// Multiset bag table: an unordered bag of keys in a table of CAPACITY words.
// req_ch carries one operation (add, remove first match, count matches, clear)
// and a key; rsp_ch returns exactly one result for each, with the entry total
// and empty flag after the operation. Both channels move a transfer when valid
// and ready are high at a rising clock edge.
// Add and clear show their result the cycle after the request transfer.
// Count compares every stored entry, one compare per cycle through the single
// read port of the entry memory. Remove reads the last entry first, then
// compares one entry per cycle up to the first match.
// One operation is in flight at a time: req_ch.ready is low from the request
// transfer until the result transfer. While the receiver stalls, the result
// holds on rsp_ch and no new request is taken.
// Reset empties the bag at once; stale memory contents are never read, so no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module multiset_bag_table import mbt_pkg::*; #(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   mbt_req_if.sink    req_ch,
   mbt_rsp_if.source  rsp_ch
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type            state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [KEY_BITS-1:0]  last_ff, last_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]     match_ff, match_in;
   logic                 done_ff, done_in;
   logic                 full_ff, full_in;

   logic                 req_fire, rsp_fire;
   opcode_type           req_op;
   logic [KEY_BITS-1:0]  req_key;
   logic                 is_full;
   logic [CNT_W-1:0]     count_last;
   logic                 hit;
   logic                 scan_end;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [KEY_BITS-1:0]  wr_data;
   logic [IDX_W-1:0]     rd_addr;
   logic [KEY_BITS-1:0]  rd_data;

   mbt_store #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign rsp_fire   = rsp_ch.valid && rsp_ch.ready;
   assign req_op     = req_ch.opcode;
   assign req_key    = KEY_BITS'(req_ch.key);
   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign count_last = count_ff - CNT_W'(1);
   assign hit        = (rd_data == key_ff);
   assign scan_end   = (cmp_idx_ff == count_last);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_op)
                  OP_ADD, OP_CLEAR: state_in = ST_RESP;
                  OP_REMOVE:        state_in = (count_ff == '0) ? ST_RESP : ST_LAST;
                  OP_COUNT:         state_in = (count_ff == '0) ? ST_RESP : ST_SCAN;
                  default:          state_in = ST_RESP;
               endcase
            end
         end
         ST_LAST: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_end || (op_ff == OP_REMOVE && hit)) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op_in      = op_ff;
      key_in     = key_ff;
      last_in    = last_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      cmp_idx_in = cmp_idx_ff;
      match_in   = match_ff;
      done_in    = done_ff;
      full_in    = full_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[IDX_W-1:0];
      wr_data    = req_key;
      rd_addr    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_op == OP_REMOVE) ? count_last[IDX_W-1:0] : '0;
            if (req_fire) begin
               op_in      = req_op;
               key_in     = req_key;
               done_in    = 1'b0;
               full_in    = 1'b0;
               match_in   = '0;
               idx_in     = CNT_W'(1);
               cmp_idx_in = '0;
               unique case (req_op)
                  OP_ADD: begin
                     if (is_full) begin
                        full_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        done_in  = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     done_in  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LAST: begin
            last_in = rd_data;
            rd_addr = '0;
         end
         ST_SCAN: begin
            rd_addr    = (idx_ff < count_ff) ? idx_ff[IDX_W-1:0] : '0;
            idx_in     = idx_ff + CNT_W'(1);
            cmp_idx_in = cmp_idx_ff + CNT_W'(1);
            if (hit) begin
               if (op_ff == OP_COUNT) begin
                  match_in = match_ff + CNT_W'(1);
               end else if (op_ff == OP_REMOVE) begin
                  wr_en    = 1'b1;
                  wr_addr  = cmp_idx_ff[IDX_W-1:0];
                  wr_data  = last_ff;
                  count_in = count_last;
                  done_in  = 1'b1;
               end
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      last_ff    <= last_in;
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      match_ff   <= match_in;
      done_ff    <= done_in;
      full_ff    <= full_in;
   end

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = (state_ff == ST_RESP);
   assign rsp_ch.done_ok       = done_ff;
   assign rsp_ch.rejected_full = full_ff;
   assign rsp_ch.match_count   = TOTAL_W'(match_ff);
   assign rsp_ch.is_present    = (match_ff != '0);
   assign rsp_ch.entry_total   = TOTAL_W'(count_ff);
   assign rsp_ch.is_empty      = (count_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request taken while result pending");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == OP_ADD && !is_full) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("add did not grow the bag");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && op_ff == OP_REMOVE && hit)
         |=> (count_ff == $past(count_ff) - CNT_W'(1)) && rsp_ch.valid && rsp_ch.done_ok)
      else $error("remove hit did not shrink the bag");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == OP_CLEAR) |=> rsp_ch.valid && rsp_ch.is_empty)
      else $error("clear left entries");

endmodule

`default_nettype wire
